/* rtl/dbld_pkg.sv */
package dbld_pkg;

    // Stream layout constants.
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned COUNT_BITS = 32;
    localparam int unsigned WIDTH_BITS = 6;
    localparam int unsigned MAX_WIDTH  = 32;
    localparam int unsigned STORE_BITS = 64;
    localparam int unsigned HELD_BITS  = 7;

    // Decoder phase codes.
    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_WIDTH = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // Take the accepted request into the bit store.
        logic step;    // Decode one field.
        logic finish;  // Release the staged result as the last of its run.
    } dbld_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fld_ready;   // Enough bits are held to decode the next field.
        logic fld_result;  // Decoding that field produces a result.
        logic pend_valid;  // A result is staged and not yet released.
        logic out_free;    // The output register can take a result now.
        logic held_low;    // Fewer than one word of bits is held.
    } dbld_status_t;

endpackage

/* rtl/delta_bitpack_list_decoder_top.sv */
// Delta bit-pack list decoder. Each request carries one 32-bit word of a packed
// stream, consumed least significant bit first; lists are a 32-bit count, a 6-bit
// width and count deltas of that width, and each result is the running sum of the
// deltas in its list. A zero count or a width of 0 or above 32 gives one error
// result with a zero id. A single field extractor decodes each accepted word from
// the bit store one field at a time (count, width, each delta) until too few bits
// remain for the next field, and closes its run before the next word is taken.
// Results leave through an output register, one per cycle, and the last result
// caused by a word carries tlast; a slow consumer stalls the extractor.
module delta_bitpack_list_decoder_top
    import dbld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] doc_id
    output logic [1:0]  m_tuser,   // [0] status, [1] list_end
    output logic        m_tlast    // run_end
);

    dbld_cmd_t    cmd;
    dbld_status_t status;

    dbld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dbld_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_word    (s_tdata),
        .in_restart (s_tuser),
        .m_tready   (m_tready),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // A new request is taken only after the previous run has been fully released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.pend_valid)
        else $error("request accepted while a result is still staged");

    // Between requests, less than one word of bits remains held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> status.held_low)
        else $error("bit store holds a full word while idle");

    // An error result carries a zero id and no list end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0 && !m_tuser[1]))
        else $error("error result with nonzero id or list end");

endmodule

/* rtl/dbld_ctrl.sv */
module dbld_ctrl
    import dbld_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  dbld_status_t status,
    output dbld_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECODE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.fld_ready) begin
                    // A new result pushes the staged one out, so it needs room.
                    if (!status.fld_result || !status.pend_valid || status.out_free) begin
                        cmd.step = 1'b1;
                    end
                end else if (!status.pend_valid || status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/dbld_datapath.sv */
module dbld_datapath
    import dbld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dbld_cmd_t            cmd,
    input  logic [WORD_BITS-1:0] in_word,
    input  logic                 in_restart,
    input  logic                 m_tready,
    output dbld_status_t         status,
    output logic                 m_tvalid,
    output logic [WORD_BITS-1:0] m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    // Decoder state.
    logic [STORE_BITS-1:0] store_reg, store_next;
    logic [HELD_BITS-1:0]  held_reg, held_next;
    logic [1:0]            phase_reg, phase_next;
    logic [WORD_BITS-1:0]  left_reg, left_next;
    logic [5:0]            fw_reg, fw_next;
    logic [WORD_BITS-1:0]  sum_reg, sum_next;

    // Staged result and output register.
    logic                 pend_valid_reg;
    logic [WORD_BITS-1:0] pend_id_reg;
    logic                 pend_status_reg;
    logic                 pend_end_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_id_reg;
    logic                 out_status_reg;
    logic                 out_end_reg;
    logic                 out_last_reg;

    // Field decode results.
    logic                 fld_ready;
    logic                 fld_result;
    logic [5:0]           take_n;
    logic [WORD_BITS-1:0] res_id;
    logic                 res_status;
    logic                 res_end;
    logic [WORD_BITS-1:0] data_mask;
    logic [WORD_BITS-1:0] data_val;
    logic [WORD_BITS-1:0] cnt_val;
    logic [5:0]           wid_val;
    logic                 data_skip;
    logic                 flush;

    assign cnt_val   = store_reg[WORD_BITS-1:0];
    assign wid_val   = store_reg[WIDTH_BITS-1:0];
    assign data_mask = {WORD_BITS{1'b1}} >> (6'(MAX_WIDTH) - fw_reg);
    assign data_val  = store_reg[WORD_BITS-1:0] & data_mask;
    assign data_skip = (fw_reg == 6'd0) || (fw_reg > 6'(MAX_WIDTH)) || (left_reg == '0);

    // Decode of the field at the bottom of the bit store.
    always_comb begin
        fld_ready  = 1'b0;
        fld_result = 1'b0;
        take_n     = 6'd0;
        res_id     = '0;
        res_status = 1'b0;
        res_end    = 1'b0;
        phase_next = phase_reg;
        left_next  = left_reg;
        fw_next    = fw_reg;
        sum_next   = sum_reg;
        case (phase_reg)
            PH_WIDTH: begin
                fld_ready = held_reg >= 7'(WIDTH_BITS);
                take_n    = 6'(WIDTH_BITS);
                if (wid_val == 6'd0 || wid_val > 6'(MAX_WIDTH)) begin
                    fld_result = 1'b1;
                    res_status = 1'b1;
                    phase_next = PH_COUNT;
                end else begin
                    fw_next    = wid_val;
                    sum_next   = '0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                if (data_skip) begin
                    // An empty or malformed list falls back to a new count.
                    fld_ready  = 1'b1;
                    phase_next = PH_COUNT;
                end else begin
                    fld_ready  = held_reg >= {1'b0, fw_reg};
                    fld_result = 1'b1;
                    take_n     = fw_reg;
                    sum_next   = sum_reg + data_val;
                    left_next  = left_reg - WORD_BITS'(1);
                    res_id     = sum_next;
                    res_end    = (left_reg == WORD_BITS'(1));
                    if (res_end) begin
                        phase_next = PH_COUNT;
                    end
                end
            end
            default: begin
                fld_ready  = held_reg >= 7'(COUNT_BITS);
                take_n     = 6'(COUNT_BITS);
                phase_next = PH_COUNT;
                if (cnt_val == '0) begin
                    fld_result = 1'b1;
                    res_status = 1'b1;
                end else begin
                    left_next  = cnt_val;
                    phase_next = PH_WIDTH;
                end
            end
        endcase
    end

    // Bit store update: append on load, consume on a step.
    always_comb begin
        logic [STORE_BITS-1:0] base_store;
        logic [HELD_BITS-1:0]  base_held;
        base_store = in_restart ? '0 : store_reg;
        base_held  = in_restart ? '0 : held_reg;
        store_next = store_reg;
        held_next  = held_reg;
        if (cmd.load) begin
            store_next = base_store | ({{(STORE_BITS-WORD_BITS){1'b0}}, in_word}
                                       << base_held);
            held_next  = base_held + 7'(WORD_BITS);
        end else if (cmd.step) begin
            store_next = store_reg >> take_n;
            held_next  = held_reg - {1'b0, take_n};
        end
    end

    // Decoder state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
            held_reg  <= '0;
            phase_reg <= PH_COUNT;
            left_reg  <= '0;
            fw_reg    <= '0;
            sum_reg   <= '0;
        end else begin
            store_reg <= store_next;
            held_reg  <= held_next;
            if (cmd.load && in_restart) begin
                phase_reg <= PH_COUNT;
                left_reg  <= '0;
                fw_reg    <= '0;
                sum_reg   <= '0;
            end else if (cmd.step) begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                fw_reg    <= fw_next;
                sum_reg   <= sum_next;
            end
        end
    end

    // The staged result moves out when a newer one arrives or the run closes.
    assign flush = pend_valid_reg && ((cmd.step && fld_result) || cmd.finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.step && fld_result) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end
            if (flush) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.step && fld_result) begin
            pend_id_reg     <= res_id;
            pend_status_reg <= res_status;
            pend_end_reg    <= res_end;
        end
        if (flush) begin
            out_id_reg     <= pend_id_reg;
            out_status_reg <= pend_status_reg;
            out_end_reg    <= pend_end_reg;
            out_last_reg   <= cmd.finish;
        end
    end

    assign status.fld_ready  = fld_ready;
    assign status.fld_result = fld_result;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.held_low   = held_reg < 7'(WORD_BITS);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = {out_end_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule
